>>> rtl/consistent_hash_ring_top_defines.svh
// Assertion macros shared by the ring modules.
// Depends on nothing; the user module supplies clk and rst.
`ifndef CONSISTENT_HASH_RING_TOP_DEFINES_SVH
`define CONSISTENT_HASH_RING_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CHR_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define CHR_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CHR_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CHR_ASSERT(label, cond, msg)
`define CHR_IMPLY(label, ante, cons, msg)
`define CHR_NEXT(label, ante, cons, msg)
`endif
`endif

>>> rtl/chr_pkg.sv
// Types, codes and hash helpers for the consistent hash ring.
// No dependencies.
package chr_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [7:0]  SEP_CHAR  = 8'h23;
  localparam logic [7:0]  ZERO_CHAR = 8'h30;
  localparam int          DIGITS    = 5;

  typedef struct packed {
    logic [31:0] hash;
    logic [3:0]  owner;
  } entry_t;

  typedef struct packed {
    logic  accept;
    logic  lu_init;
    logic  srch_rd;
    logic  srch_step;
    logic  drop_init;
    logic  drop_rd;
    logic  drop_wr;
    logic  drop_end;
    logic  add_init;
    logic  pt_start;
    logic  pt_digit;
    logic  ins_init;
    logic  chk_rd;
    logic  ovw_wr;
    logic  ins_drop;
    logic  shift_init;
    logic  shift_rd;
    logic  shift_wr;
    logic  ins_wr;
    logic  pt_next;
    logic  lu_rd;
    logic  res_load;
    kind_t res_kind;
  } cmd_t;

  typedef struct packed {
    logic id_ok;
    logic srch_done;
    logic drop_done;
    logic pt_done;
    logic dig_last;
    logic eq;
    logic full;
    logic shift_done;
    logic out_free;
  } sts_t;

  function automatic logic [31:0] fnv_fold(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * FNV_PRIME;
  endfunction

endpackage

>>> rtl/chr_datapath.sv
// Ring memory, hash registers, search and point counters, result register.
// Depends on chr_pkg and the assertion macro header.
`include "consistent_hash_ring_top_defines.svh"
module chr_datapath
  import chr_pkg::*;
#(
  parameter int RING_DEPTH = 1024,
  parameter int NODE_COUNT = 16,
  parameter int AW = $clog2(RING_DEPTH),
  parameter int CW = $clog2(RING_DEPTH + 1)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  op_t         in_op,
  input  logic [7:0]  in_byte,
  input  logic [3:0]  in_id,
  input  logic [7:0]  in_weight,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        out_ready,
  output logic        out_valid,
  output kind_t       out_kind,
  output logic [3:0]  out_owner,
  output logic        out_hit,
  output logic        out_ovf,
  output logic [CW-1:0] out_points
);

  entry_t mem [RING_DEPTH];
  entry_t rdata;
  entry_t wdata;
  logic [AW-1:0] raddr, waddr;
  logic re, we;

  logic [7:0]    vpw;
  logic [31:0]   running, base, key;
  logic [3:0]    id;
  logic [7:0]    weight;
  logic [15:0]   total, idx_i;
  logic [3:0]    bcd [DIGITS];
  logic [3:0]    bcd_next [DIGITS];
  logic [2:0]    dig, ndig_m1;
  logic [CW-1:0] count, lo, hi, rp, wp, sp;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid;
  logic          ovf;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[CW:1];

  always_comb begin
    ndig_m1 = '0;
    for (int k = 0; k < DIGITS; k++) begin
      if (bcd[k] != 4'd0) ndig_m1 = 3'(k);
    end
  end

  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int k = 0; k < DIGITS; k++) begin
      if (carry && bcd[k] == 4'd9) begin
        bcd_next[k] = 4'd0;
      end else begin
        bcd_next[k] = bcd[k] + {3'd0, carry};
        carry = 1'b0;
      end
    end
  end

  always_comb begin
    re    = 1'b1;
    raddr = '0;
    if (cmd.srch_rd) begin
      raddr = mid[AW-1:0];
    end else if (cmd.drop_rd) begin
      raddr = rp[AW-1:0];
    end else if (cmd.chk_rd) begin
      raddr = lo[AW-1:0];
    end else if (cmd.shift_rd) begin
      raddr = AW'(sp - CW'(1));
    end else if (cmd.lu_rd) begin
      raddr = (lo >= count) ? '0 : lo[AW-1:0];
    end else begin
      re = 1'b0;
    end
  end

  always_comb begin
    we    = 1'b1;
    waddr = '0;
    wdata = rdata;
    if (cmd.drop_wr) begin
      we    = (rdata.owner != id);
      waddr = wp[AW-1:0];
    end else if (cmd.ovw_wr || cmd.ins_wr) begin
      waddr = lo[AW-1:0];
      wdata = '{hash: key, owner: id};
    end else if (cmd.shift_wr) begin
      waddr = sp[AW-1:0];
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpw       <= 8'd16;
      running   <= FNV_BASIS;
      count     <= '0;
      lo        <= '0;
      hi        <= '0;
      rp        <= '0;
      wp        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) vpw <= cfg_data;
      if (cmd.accept) begin
        id     <= in_id;
        weight <= in_weight;
        if (in_op == OP_ADD || in_op == OP_LOOKUP) running <= fnv_fold(running, in_byte);
      end
      if (cmd.lu_init) begin
        key     <= running;
        running <= FNV_BASIS;
        lo      <= '0;
        hi      <= count;
      end
      if (cmd.add_init) begin
        base    <= fnv_fold(running, SEP_CHAR);
        running <= FNV_BASIS;
        total   <= {8'd0, weight} * {8'd0, vpw};
        idx_i   <= '0;
        ovf     <= 1'b0;
        for (int k = 0; k < DIGITS; k++) bcd[k] <= 4'd0;
      end
      if (cmd.srch_step) begin
        if (rdata.hash < key) lo <= mid + CW'(1);
        else hi <= mid;
      end
      if (cmd.drop_init) begin
        rp <= '0;
        wp <= '0;
      end
      if (cmd.drop_wr) begin
        rp <= rp + CW'(1);
        if (rdata.owner != id) wp <= wp + CW'(1);
      end
      if (cmd.drop_end) count <= wp;
      if (cmd.pt_start) begin
        key <= base;
        dig <= ndig_m1;
      end
      if (cmd.pt_digit) begin
        key <= fnv_fold(key, ZERO_CHAR | {4'd0, bcd[dig]});
        dig <= dig - 3'd1;
      end
      if (cmd.ins_init) begin
        lo <= '0;
        hi <= count;
      end
      if (cmd.ins_drop) ovf <= 1'b1;
      if (cmd.shift_init) sp <= count;
      if (cmd.shift_wr) sp <= sp - CW'(1);
      if (cmd.ins_wr) count <= count + CW'(1);
      if (cmd.pt_next) begin
        idx_i <= idx_i + 16'd1;
        for (int k = 0; k < DIGITS; k++) bcd[k] <= bcd_next[k];
      end
      if (cmd.res_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_kind   <= cmd.res_kind;
      out_points <= count;
      if (cmd.res_kind == KIND_LOOKUP) begin
        out_owner <= (count != '0) ? rdata.owner : 4'd0;
        out_hit   <= (count != '0);
        out_ovf   <= 1'b0;
      end else begin
        out_owner <= id;
        out_hit   <= 1'b0;
        out_ovf   <= (cmd.res_kind == KIND_ADD) && ovf;
      end
    end
  end

  always_comb begin
    sts.id_ok      = (32'(id) < NODE_COUNT);
    sts.srch_done  = (lo >= hi);
    sts.drop_done  = (rp >= count);
    sts.pt_done    = (idx_i >= total);
    sts.dig_last   = (dig == 3'd0);
    sts.eq         = (lo < count) && (rdata.hash == key);
    sts.full       = (32'(count) >= RING_DEPTH);
    sts.shift_done = (sp <= lo);
    sts.out_free   = !out_valid || out_ready;
  end

  `CHR_ASSERT(a_count_bound, 32'(count) <= RING_DEPTH, "point count above ring depth")
  `CHR_ASSERT(a_search_order, lo <= hi, "search window inverted")
  `CHR_ASSERT(a_drop_order, wp <= rp, "compaction write pointer passed read pointer")
  `CHR_NEXT(a_result_shown, cmd.res_load, out_valid, "loaded result not presented")

endmodule

>>> rtl/chr_controller.sv
// Sequencer for hashing, ring search, compaction and point insertion.
// Depends on chr_pkg and the assertion macro header.
`include "consistent_hash_ring_top_defines.svh"
module chr_controller
  import chr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  op_t  in_op,
  input  logic in_last,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    IDLE, LU_INIT, ADD_INIT, DROP_INIT, DROP_RD, DROP_WR, PT_CHK, PT_DIG,
    INS_INIT, SRCH, SRCH_W, CHK_RD, CHK, SHIFT, SHIFT_W, PT_NEXT, LU_RD, RES
  } state_t;

  state_t state, state_next;
  kind_t  kind;
  logic   is_ins;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd          = '0;
    cmd.res_kind = kind;
    state_next   = state;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (in_op)
            OP_REMOVE: state_next = DROP_INIT;
            OP_ADD:    if (in_last) state_next = ADD_INIT;
            OP_LOOKUP: if (in_last) state_next = LU_INIT;
            default:   state_next = IDLE;
          endcase
        end
      end
      LU_INIT: begin
        cmd.lu_init = 1'b1;
        state_next  = SRCH;
      end
      ADD_INIT: begin
        cmd.add_init = 1'b1;
        state_next   = sts.id_ok ? DROP_INIT : RES;
      end
      DROP_INIT: begin
        if (sts.id_ok) begin
          cmd.drop_init = 1'b1;
          state_next    = DROP_RD;
        end else begin
          state_next = RES;
        end
      end
      DROP_RD: begin
        if (sts.drop_done) begin
          cmd.drop_end = 1'b1;
          state_next   = (kind == KIND_ADD) ? PT_CHK : RES;
        end else begin
          cmd.drop_rd = 1'b1;
          state_next  = DROP_WR;
        end
      end
      DROP_WR: begin
        cmd.drop_wr = 1'b1;
        state_next  = DROP_RD;
      end
      PT_CHK: begin
        if (sts.pt_done) begin
          state_next = RES;
        end else begin
          cmd.pt_start = 1'b1;
          state_next   = PT_DIG;
        end
      end
      PT_DIG: begin
        cmd.pt_digit = 1'b1;
        if (sts.dig_last) state_next = INS_INIT;
      end
      INS_INIT: begin
        cmd.ins_init = 1'b1;
        state_next   = SRCH;
      end
      SRCH: begin
        if (sts.srch_done) begin
          state_next = is_ins ? CHK_RD : LU_RD;
        end else begin
          cmd.srch_rd = 1'b1;
          state_next  = SRCH_W;
        end
      end
      SRCH_W: begin
        cmd.srch_step = 1'b1;
        state_next    = SRCH;
      end
      CHK_RD: begin
        cmd.chk_rd = 1'b1;
        state_next = CHK;
      end
      CHK: begin
        if (sts.eq) begin
          cmd.ovw_wr = 1'b1;
          state_next = PT_NEXT;
        end else if (sts.full) begin
          cmd.ins_drop = 1'b1;
          state_next   = PT_NEXT;
        end else begin
          cmd.shift_init = 1'b1;
          state_next     = SHIFT;
        end
      end
      SHIFT: begin
        if (sts.shift_done) begin
          cmd.ins_wr = 1'b1;
          state_next = PT_NEXT;
        end else begin
          cmd.shift_rd = 1'b1;
          state_next   = SHIFT_W;
        end
      end
      SHIFT_W: begin
        cmd.shift_wr = 1'b1;
        state_next   = SHIFT;
      end
      PT_NEXT: begin
        cmd.pt_next = 1'b1;
        state_next  = PT_CHK;
      end
      LU_RD: begin
        cmd.lu_rd  = 1'b1;
        state_next = RES;
      end
      RES: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      kind   <= KIND_LOOKUP;
      is_ins <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.accept) begin
        case (in_op)
          OP_REMOVE: kind <= KIND_REMOVE;
          OP_ADD:    kind <= KIND_ADD;
          default:   kind <= KIND_LOOKUP;
        endcase
      end
      if (cmd.lu_init) is_ins <= 1'b0;
      if (cmd.ins_init) is_ins <= 1'b1;
    end
  end

  `CHR_IMPLY(a_res_room, cmd.res_load, sts.out_free, "result loaded over a pending result")
  `CHR_IMPLY(a_ins_room, cmd.ins_wr, !sts.full, "insertion into a full ring")
  `CHR_ASSERT(a_one_write, $onehot0({cmd.drop_wr, cmd.ovw_wr, cmd.shift_wr, cmd.ins_wr}),
              "two ring writes in one cycle")

endmodule

>>> rtl/consistent_hash_ring_top.sv
// Consistent hash ring: one command at a time, s_tready is high only while idle.
// A name or key byte without last is folded into the hash and the block stays idle. A lookup
// searches the ring by bisection, then reads the found point and loads the result; a remove
// compacts the ring. An add compacts, then per new point hashes its digits, searches, and
// either overwrites an equal hash, drops it when full, or shifts the points above it and inserts.
// Reset (rst, synchronous) empties the ring and restores the register to 16.
module consistent_hash_ring_top
  import chr_pkg::*;
#(
  parameter int RING_DEPTH = 1024,
  parameter int NODE_COUNT = 16,
  parameter int CW = $clog2(RING_DEPTH + 1),
  parameter int OW = ((6 + CW + 7) / 8) * 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_data,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [23:0]   s_tdata,   // data_byte[7:0], node_id[11:8], weight[19:12]
  input  logic [1:0]    s_tuser,   // op
  input  logic          s_tlast,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [OW-1:0] m_tdata,   // owner[3:0], hit[4], overflow[5], points above
  output logic [1:0]    m_tuser    // kind
);

  cmd_t          cmd;
  sts_t          sts;
  kind_t         out_kind;
  logic [3:0]    out_owner;
  logic          out_hit, out_ovf;
  logic [CW-1:0] out_points;
  op_t           in_op;

  assign in_op = op_t'(s_tuser);

  chr_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (in_op),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  chr_datapath #(
    .RING_DEPTH (RING_DEPTH),
    .NODE_COUNT (NODE_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_op      (in_op),
    .in_byte    (s_tdata[7:0]),
    .in_id      (s_tdata[11:8]),
    .in_weight  (s_tdata[19:12]),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_kind   (out_kind),
    .out_owner  (out_owner),
    .out_hit    (out_hit),
    .out_ovf    (out_ovf),
    .out_points (out_points)
  );

  assign m_tuser = out_kind;
  assign m_tdata = OW'({out_points, out_ovf, out_hit, out_owner});

endmodule
